### hw/rtl/box_average_downsampler_core_defines.svh
// Assertion macros used by the box average downsampler core
`ifndef BOX_AVERAGE_DOWNSAMPLER_CORE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define BXAVG_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define BXAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BXAVG_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)
`define BXAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/bxavg_pkg.sv
// Shared types and constants of the box average downsampler
`timescale 1ns / 1ps
`default_nettype none

package bxavg_pkg;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int BF_W       = 5;
  localparam int DIM_REG_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int N_CH       = 3;

  // Defaults of the top level parameters
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_FACTOR = 16;

  // Depth of the result queue
  localparam int FIFO_DEPTH = 8;

  // Register values after reset
  localparam logic [BF_W-1:0]      RST_BLOCK_FACTOR = 5'd2;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_FACTOR = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eof;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/box_average_downsampler_core.sv
// Top level of the box average downsampler
// Takes RGB pixels in raster order and gives one pixel per whole n-by-n block,
// each channel the truncated block mean; columns and rows past the last whole
// block are dropped and end_of_frame marks the last pixel of the reduced frame.
// Sustained rate is one pixel per clock while in_ready is high: a pixel reads
// its column sum from the line store, adds to it in the next cycle and writes
// it back, with the last write forwarded to a following pixel of the same
// block. A result passes the accumulate, scale and output registers and waits
// in an eight-entry queue; in_ready drops while that queue and the results in
// flight fill it. The division by n*n is a multiply by a reciprocal that a
// bit-serial divider forms after reset and after each block_factor write;
// in_ready stays low while it works. Any register write restarts the frame at
// its top left pixel. The line store needs no clearing: the first pixel of each
// block overwrites its entry.
`timescale 1ns / 1ps
`default_nettype none

`include "box_average_downsampler_core_defines.svh"

module box_average_downsampler_core #(
  parameter int MAX_WIDTH  = bxavg_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_FACTOR = bxavg_pkg::DEFAULT_MAX_FACTOR
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bxavg_pkg::PIX_W-1:0]      in_red_in,
  input  logic [bxavg_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bxavg_pkg::PIX_W-1:0]      in_blue_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bxavg_pkg::PIX_W-1:0]      out_red_out,
  output logic [bxavg_pkg::PIX_W-1:0]      out_green_out,
  output logic [bxavg_pkg::PIX_W-1:0]      out_blue_out,
  output logic                             out_end_of_frame,
  input  logic                             cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bxavg_pkg::*;

  localparam int FACT_W = $clog2(MAX_FACTOR + 1);
  localparam int CIB_W  = $clog2(MAX_FACTOR);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int E_W    = ((DIM_W > FACT_W) ? DIM_W : FACT_W) + 1;
  localparam int SUM_W  = PIX_W + 2 * CIB_W;
  localparam int AREA_W = 2 * FACT_W;
  localparam int SHIFT  = SUM_W + 2 * CIB_W;
  localparam int RC_W   = SHIFT + 1;
  localparam int PROD_W = SUM_W + RC_W;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W  = FCNT_W + 2;

  // Configuration registers
  logic [BF_W-1:0]      block_factor_r;
  logic [DIM_REG_W-1:0] frame_width_r;
  logic [DIM_REG_W-1:0] frame_height_r;
  logic                 start_r;
  logic                 cfg_hit;

  // Clamped working values
  logic [FACT_W-1:0] n_eff;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [AREA_W-1:0] area;

  // Position counters
  logic [COL_W-1:0] in_col_r,  in_col_nxt;
  logic [COL_W-1:0] in_row_r,  in_row_nxt;
  logic [CIB_W-1:0] cib_r,     cib_nxt;
  logic [CIB_W-1:0] rib_r,     rib_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;

  logic [E_W-1:0] col_e, row_e, cib_e, rib_e, n_e, w_e, h_e;
  logic accept, col_fit, row_fit, first, blk_end, last_col, last_row;
  logic col_wrap, row_wrap, cib_wrap, rib_wrap;

  // Accumulate stage
  logic                   s1_v_r;
  logic [COL_W-1:0]       s1_addr_r;
  logic                   s1_first_r;
  logic                   s1_res_r;
  logic                   s1_eof_r;
  logic [N_CH*PIX_W-1:0]  s1_px_r;
  logic [N_CH*SUM_W-1:0]  mem_rd;
  logic [N_CH*SUM_W-1:0]  base;
  logic [N_CH*SUM_W-1:0]  sum_vec;

  // Forwarding of the last write
  logic                   fwd_v_r;
  logic [COL_W-1:0]       fwd_addr_r;
  logic [N_CH*SUM_W-1:0]  fwd_data_r;

  // Scale and output stages
  logic                   s2_v_r;
  logic [N_CH*SUM_W-1:0]  s2_sum_r;
  logic                   s2_eof_r;
  logic [PROD_W-1:0]      prod [N_CH];
  logic                   s3_v_r;
  logic [N_CH*PIX_W-1:0]  s3_q_r;
  logic                   s3_eof_r;

  logic                   recip_busy;
  logic [RC_W-1:0]        recip;
  out_item_t              push_item;
  out_item_t              fifo_item;
  logic [FCNT_W-1:0]      fifo_count;
  logic [OCC_W-1:0]       occ;

  // Clamp register values into range
  always_comb begin
    if (block_factor_r == '0) begin
      n_eff = FACT_W'(1);
    end else if (32'(block_factor_r) > 32'(MAX_FACTOR)) begin
      n_eff = FACT_W'(MAX_FACTOR);
    end else begin
      n_eff = FACT_W'(block_factor_r);
    end
    if (frame_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_WIDTH)) begin
      h_eff = DIM_W'(MAX_WIDTH);
    end else begin
      h_eff = DIM_W'(frame_height_r);
    end
  end

  assign area = AREA_W'(n_eff) * AREA_W'(n_eff);

  // Decode register writes
  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_BLOCK_FACTOR: cfg_hit = cfg_we;
      REG_FRAME_WIDTH:  cfg_hit = cfg_we;
      REG_FRAME_HEIGHT: cfg_hit = cfg_we;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_factor_r <= RST_BLOCK_FACTOR;
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      start_r        <= 1'b1;
    end else begin
      start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_BLOCK_FACTOR: begin
            block_factor_r <= cfg_data[BF_W-1:0];
            start_r        <= 1'b1;
          end
          REG_FRAME_WIDTH: begin
            frame_width_r <= cfg_data[DIM_REG_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            frame_height_r <= cfg_data[DIM_REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Position tests on widened values
  assign col_e = E_W'(in_col_r);
  assign row_e = E_W'(in_row_r);
  assign cib_e = E_W'(cib_r);
  assign rib_e = E_W'(rib_r);
  assign n_e   = E_W'(n_eff);
  assign w_e   = E_W'(w_eff);
  assign h_e   = E_W'(h_eff);

  assign accept   = in_valid && in_ready;
  assign col_fit  = (col_e - cib_e + n_e) <= w_e;
  assign row_fit  = (row_e - rib_e + n_e) <= h_e;
  assign first    = (cib_r == '0) && (rib_r == '0);
  assign blk_end  = (cib_e + E_W'(1) == n_e) && (rib_e + E_W'(1) == n_e);
  assign last_col = (col_e + E_W'(1) + n_e) > w_e;
  assign last_row = (row_e + E_W'(1) + n_e) > h_e;
  assign col_wrap = (col_e + E_W'(1)) >= w_e;
  assign row_wrap = (row_e + E_W'(1)) >= h_e;
  assign cib_wrap = (cib_e + E_W'(1)) >= n_e;
  assign rib_wrap = (rib_e + E_W'(1)) >= n_e;

  // Advance the raster position
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    out_col_nxt = out_col_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      cib_nxt     = '0;
      rib_nxt     = '0;
      out_col_nxt = '0;
    end else if (accept) begin
      if (col_wrap) begin
        in_col_nxt  = '0;
        cib_nxt     = '0;
        out_col_nxt = '0;
        if (row_wrap) begin
          in_row_nxt = '0;
          rib_nxt    = '0;
        end else begin
          in_row_nxt = in_row_r + COL_W'(1);
          rib_nxt    = rib_wrap ? '0 : rib_r + CIB_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
        if (cib_wrap) begin
          cib_nxt     = '0;
          out_col_nxt = out_col_r + COL_W'(1);
        end else begin
          cib_nxt = cib_r + CIB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      out_col_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // Issue the read of the column sum and latch the pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept && col_fit && row_fit;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= out_col_r;
    s1_first_r <= first;
    s1_res_r   <= blk_end;
    s1_eof_r   <= last_col && last_row;
    s1_px_r    <= {in_red_in, in_green_in, in_blue_in};
  end

  bxavg_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (N_CH * SUM_W)
  ) u_line_store (
    .clk     (clk),
    .rd_addr (out_col_r),
    .rd_data (mem_rd),
    .wr_en   (s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_data (sum_vec)
  );

  // Add the pixel, taking the previous write where it hits the same entry
  always_comb begin
    base = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : mem_rd;
    for (int ch = 0; ch < N_CH; ch++) begin
      sum_vec[ch*SUM_W +: SUM_W] = s1_first_r ? SUM_W'(s1_px_r[ch*PIX_W +: PIX_W])
        : base[ch*SUM_W +: SUM_W] + SUM_W'(s1_px_r[ch*PIX_W +: PIX_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      fwd_v_r <= s1_v_r;
      s2_v_r  <= s1_v_r && s1_res_r;
      s3_v_r  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= sum_vec;
    s2_sum_r   <= sum_vec;
    s2_eof_r   <= s1_eof_r;
  end

  // Divide by the block area through the reciprocal
  bxavg_recip #(
    .DIV_W (AREA_W),
    .QUO_W (RC_W)
  ) u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .divisor (area),
    .busy    (recip_busy),
    .recip   (recip)
  );

  always_comb begin
    for (int ch = 0; ch < N_CH; ch++) begin
      prod[ch] = PROD_W'(s2_sum_r[ch*SUM_W +: SUM_W]) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < N_CH; ch++) begin
      s3_q_r[ch*PIX_W +: PIX_W] <= prod[ch][SHIFT +: PIX_W];
    end
    s3_eof_r <= s2_eof_r;
  end

  // Queue results for the output channel
  assign push_item.red   = s3_q_r[2*PIX_W +: PIX_W];
  assign push_item.green = s3_q_r[PIX_W +: PIX_W];
  assign push_item.blue  = s3_q_r[0 +: PIX_W];
  assign push_item.eof   = s3_eof_r;

  bxavg_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r),
    .push_item (push_item),
    .pop       (out_ready),
    .valid     (out_valid),
    .item      (fifo_item),
    .count     (fifo_count)
  );

  assign out_red_out      = fifo_item.red;
  assign out_green_out    = fifo_item.green;
  assign out_blue_out     = fifo_item.blue;
  assign out_end_of_frame = fifo_item.eof;

  // Hold input while the reciprocal forms or the queue could overrun
  assign occ = OCC_W'(fifo_count) + OCC_W'(s1_v_r && s1_res_r) + OCC_W'(s2_v_r)
             + OCC_W'(s3_v_r);
  assign in_ready = !start_r && !recip_busy && (occ < OCC_W'(FIFO_DEPTH));

  // Checks
  `BXAVG_ASSERT_HOLDS(a_occ_bound, clk, rst_n, occ <= OCC_W'(FIFO_DEPTH), "result queue overrun")
  `BXAVG_ASSERT_HOLDS(a_blk_pos, clk, rst_n, (cib_e < n_e) && (rib_e < n_e), "block position out of block")
  `BXAVG_ASSERT_HOLDS(a_frame_pos, clk, rst_n, (col_e < w_e) && (row_e < h_e), "position out of frame")
  `BXAVG_ASSERT_NEXT(a_scale_src, clk, rst_n, s1_v_r && s1_res_r, s2_v_r, "block result lost before scaling")

endmodule

`default_nettype wire

### hw/rtl/bxavg_line_store.sv
// Line store of per-column block sums, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bxavg_line_store #(
  parameter int DEPTH  = bxavg_pkg::DEFAULT_MAX_WIDTH,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read old contents, write at the same edge
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bxavg_recip.sv
// Bit-serial divider forming the rounded-up reciprocal of the block area
`timescale 1ns / 1ps
`default_nettype none

module bxavg_recip #(
  parameter int DIV_W = 10,
  parameter int QUO_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] recip
);

  localparam int SHIFT = QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_r;
  logic [QUO_W-1:0] dq_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W:0]   trial;
  logic             take;
  logic [QUO_W-1:0] dividend;

  // Dividend 2^SHIFT + d - 1 gives the ceiling of 2^SHIFT / d
  assign dividend = (QUO_W'(1) << SHIFT) + QUO_W'(divisor) - QUO_W'(1);

  // Shift in one dividend bit, subtract where it fits
  assign trial = {rem_r, dq_r[QUO_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(QUO_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= take ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
      dq_r  <= {dq_r[QUO_W-2:0], take};
    end
  end

  assign busy  = (cnt_r != '0);
  assign recip = dq_r;

endmodule

`default_nettype wire

### hw/rtl/bxavg_out_fifo.sv
// Result queue between the datapath and the output channel
`timescale 1ns / 1ps
`default_nettype none

module bxavg_out_fifo #(
  parameter int DEPTH = bxavg_pkg::FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bxavg_pkg::out_item_t       push_item,
  input  logic                       pop,
  output logic                       valid,
  output bxavg_pkg::out_item_t       item,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  import bxavg_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign valid  = (count_r != '0);
  assign item   = slots[rd_ptr_r];
  assign count  = count_r;
  assign do_pop = pop && valid;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire
